### hdl/hdlc_frame_deframer_core_macros.svh
// Assertion macros for the HDLC frame deframer.
`ifndef HDLC_FRAME_DEFRAMER_CORE_MACROS_SVH
`define HDLC_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HDLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HDLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hdlc_dfr_pkg.sv
// Constants and codes shared by the HDLC frame deframer.
package hdlc_dfr_pkg;

    localparam int MAX_FRAME_DEF = 4096;

    localparam int BYTE_W     = 8;
    localparam int EVENT_W    = 3;
    localparam int INDEX_W    = 12;
    localparam int LENGTH_W   = 13;

    localparam logic [LENGTH_W-1:0] EXP_LEN_RESET = 13'd4096;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h5E;
    localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h5D;

    localparam logic [EVENT_W-1:0] EV_DATA   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_DONE   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_OVER   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_BADESC = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DROP   = 3'd4;

endpackage

### hdl/hdlc_frame_deframer_core.sv
// HDLC byte destuffing deframer: flag hunt, escape removal, length check.
//
// Takes one received byte per cycle on the input channel and gives at most one
// result item per byte: a decoded payload byte with its index, a frame
// complete with its length, or an error (overflow, bad escape, wrong length).
// Each byte is decoded combinationally against the phase and byte count and
// the result lands in an output register, so a byte is accepted every cycle
// while the output is free or being taken; the only stall comes from
// out_ready. A result appears in the cycle after its byte is accepted. The
// expected length register resets to 4096 and is written through the cfg
// channel, which is always ready; write it only while the block is idle.
`include "hdlc_frame_deframer_core_macros.svh"

module hdlc_frame_deframer_core #(
    parameter int MAX_FRAME = hdlc_dfr_pkg::MAX_FRAME_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hdlc_dfr_pkg::LENGTH_W-1:0]    cfg_data,
    // received bytes
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [hdlc_dfr_pkg::BYTE_W-1:0]      rx_byte,
    // results
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [hdlc_dfr_pkg::EVENT_W-1:0]     event_res,
    output logic [hdlc_dfr_pkg::BYTE_W-1:0]      data_byte,
    output logic [hdlc_dfr_pkg::INDEX_W-1:0]     byte_index,
    output logic [hdlc_dfr_pkg::LENGTH_W-1:0]    frame_length
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = (CNT_W > hdlc_dfr_pkg::LENGTH_W) ? CNT_W : hdlc_dfr_pkg::LENGTH_W;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FLAG,
        PH_DATA,
        PH_ESC
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [hdlc_dfr_pkg::LENGTH_W-1:0]   exp_len_reg;

    logic                                out_valid_reg;
    logic [hdlc_dfr_pkg::EVENT_W-1:0]    event_reg, event_next;
    logic [hdlc_dfr_pkg::BYTE_W-1:0]     data_reg, data_next;
    logic [hdlc_dfr_pkg::INDEX_W-1:0]    index_reg, index_next;
    logic [hdlc_dfr_pkg::LENGTH_W-1:0]   length_reg, length_next;
    logic                                emit_next;

    logic                                accept;
    logic                                is_payload;
    logic [hdlc_dfr_pkg::BYTE_W-1:0]     payload_byte;
    logic                                full;
    logic                                len_match;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign full = (CMP_W'(count_reg) >= CMP_W'(exp_len_reg))
               || (count_reg >= CNT_W'(MAX_FRAME));
    assign len_match = (CMP_W'(count_reg) == CMP_W'(exp_len_reg));

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        emit_next    = 1'b0;
        event_next   = hdlc_dfr_pkg::EV_DATA;
        length_next  = '0;
        is_payload   = 1'b0;
        payload_byte = rx_byte;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == hdlc_dfr_pkg::FLAG_BYTE)
                begin
                    phase_next = PH_FLAG;
                    count_next = '0;
                end
            end
            PH_FLAG:
            begin
                if (rx_byte == hdlc_dfr_pkg::ESC_BYTE)
                    phase_next = PH_ESC;
                else if (rx_byte != hdlc_dfr_pkg::FLAG_BYTE)
                    is_payload = 1'b1;
            end
            PH_DATA:
            begin
                if (rx_byte == hdlc_dfr_pkg::ESC_BYTE)
                    phase_next = PH_ESC;
                else if (rx_byte == hdlc_dfr_pkg::FLAG_BYTE)
                begin
                    // closing flag: report and go back to hunting
                    phase_next = PH_HUNT;
                    count_next = '0;
                    emit_next  = 1'b1;
                    if (len_match)
                    begin
                        event_next  = hdlc_dfr_pkg::EV_DONE;
                        length_next = hdlc_dfr_pkg::LENGTH_W'(count_reg);
                    end
                    else
                        event_next = hdlc_dfr_pkg::EV_DROP;
                end
                else
                    is_payload = 1'b1;
            end
            PH_ESC:
            begin
                if (rx_byte == hdlc_dfr_pkg::ESC_FLAG)
                begin
                    is_payload   = 1'b1;
                    payload_byte = hdlc_dfr_pkg::FLAG_BYTE;
                end
                else if (rx_byte == hdlc_dfr_pkg::ESC_ESC)
                begin
                    is_payload   = 1'b1;
                    payload_byte = hdlc_dfr_pkg::ESC_BYTE;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    emit_next  = 1'b1;
                    event_next = hdlc_dfr_pkg::EV_BADESC;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                count_next = '0;
            end
        endcase

        if (is_payload)
        begin
            emit_next = 1'b1;
            if (full)
            begin
                // overflow: drop the frame
                phase_next = PH_HUNT;
                count_next = '0;
                event_next = hdlc_dfr_pkg::EV_OVER;
            end
            else
            begin
                phase_next = PH_DATA;
                count_next = count_reg + 1'b1;
                event_next = hdlc_dfr_pkg::EV_DATA;
            end
        end

        data_next  = (is_payload && !full) ? payload_byte : '0;
        index_next = (is_payload && !full) ? hdlc_dfr_pkg::INDEX_W'(count_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            exp_len_reg   <= hdlc_dfr_pkg::EXP_LEN_RESET;
            out_valid_reg <= 1'b0;
            event_reg     <= hdlc_dfr_pkg::EV_DATA;
            data_reg      <= '0;
            index_reg     <= '0;
            length_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                exp_len_reg <= cfg_data;
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
            if (in_ready)
                out_valid_reg <= accept && emit_next;
            if (accept && emit_next)
            begin
                event_reg  <= event_next;
                data_reg   <= data_next;
                index_reg  <= index_next;
                length_reg <= length_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign data_byte    = data_reg;
    assign byte_index   = index_reg;
    assign frame_length = length_reg;

    `HDLC_ASSERT_IMP(a_end_clears_state, out_valid_reg && (event_reg != hdlc_dfr_pkg::EV_DATA), (phase_reg == PH_HUNT) && (count_reg == '0), "frame end or error left state live")
    `HDLC_ASSERT_IMP(a_data_in_frame, out_valid_reg && (event_reg == hdlc_dfr_pkg::EV_DATA), (phase_reg == PH_DATA) && (count_reg != '0), "data item without open frame")
    `HDLC_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= CNT_W'(MAX_FRAME), "byte count beyond frame limit")
    `HDLC_ASSERT_IMP(a_done_length, out_valid_reg && (event_reg == hdlc_dfr_pkg::EV_DONE), length_reg == exp_len_reg, "completed frame length differs from expected")
    `HDLC_ASSERT_NXT(a_stall_holds_state, out_valid_reg && !out_ready, $stable(phase_reg) && $stable(count_reg), "state moved while output stalled")

endmodule
